/* rtl/core/nsfs_pkg.sv */
// Package for the NMEA sentence field splitter: sizes, character and status
// codes, item and result types, controller state and control structs.
// Depends on nothing; every other file of the block but nsfs_ram imports it.
package nsfs_pkg;

    // Storage sizes
    localparam int LINE_BYTES  = 128;
    localparam int MAX_FIELDS  = 20;
    localparam int FIELD_BYTES = 16;
    localparam int KINDS       = 7;

    localparam int SLOTS      = KINDS * MAX_FIELDS;
    localparam int CHAR_DEPTH = SLOTS * FIELD_BYTES;
    localparam int LINE_AW    = $clog2(LINE_BYTES);
    localparam int POS_W      = $clog2(LINE_BYTES + 1);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
    localparam int CUR_W      = $clog2(MAX_FIELDS + 1);
    localparam int FCNT_W     = $clog2(FIELD_BYTES + 1);
    localparam int FIDX_W     = $clog2(FIELD_BYTES);
    localparam int META_W     = FIDX_W + 1;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Header names, characters 3 to 5
    localparam logic [23:0] HDR_RMC = {8'h52, 8'h4D, 8'h43};
    localparam logic [23:0] HDR_VTG = {8'h56, 8'h54, 8'h47};
    localparam logic [23:0] HDR_GGA = {8'h47, 8'h47, 8'h41};
    localparam logic [23:0] HDR_GSA = {8'h47, 8'h53, 8'h41};
    localparam logic [23:0] HDR_GSV = {8'h47, 8'h53, 8'h56};
    localparam logic [23:0] HDR_GLL = {8'h47, 8'h4C, 8'h4C};

    // Sentence kinds
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_RMC     = 3'd1;
    localparam logic [2:0] KIND_VTG     = 3'd2;
    localparam logic [2:0] KIND_GGA     = 3'd3;
    localparam logic [2:0] KIND_GSA     = 3'd4;
    localparam logic [2:0] KIND_GSV     = 3'd5;
    localparam logic [2:0] KIND_GLL     = 3'd6;

    // Result status codes
    localparam logic [2:0] ST_BYTE    = 3'd0;
    localparam logic [2:0] ST_STORED  = 3'd1;
    localparam logic [2:0] ST_DISCARD = 3'd2;
    localparam logic [2:0] ST_OK      = 3'd3;
    localparam logic [2:0] ST_NODATA  = 3'd4;
    localparam logic [2:0] ST_OVF     = 3'd5;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [2:0] sentence_kind;
        logic [4:0] field_number;
        logic [7:0] dest_capacity;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] kind_out;
        logic [3:0] field_len;
        logic [7:0] data_byte;
        logic       last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_SPLIT_RD,
        S_SPLIT_PROC,
        S_SPLIT_FIN,
        S_RD_META,
        S_RD_DEC,
        S_CHR_RD,
        S_CHR_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic byte_exec;
        logic split_init;
        logic line_rd;
        logic split_step;
        logic split_fin;
        logic meta_rd;
        logic rd_single;
        logic chr_start;
        logic chr_rd;
        logic chr_emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic line_end;
        logic at_end;
        logic rd_ok;
        logic chr_last;
    } sts_t;

endpackage

/* rtl/core/nsfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nsfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/nsfs_ctrl.sv */
// Controller of the field splitter: sequences byte handling, the split pass
// and field reads. Depends on nsfs_pkg.
module nsfs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           req_type,
    output logic           busy,
    output nsfs_pkg::cmd_t cmd,
    input  nsfs_pkg::sts_t sts
);

    import nsfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_type == REQ_READ) ? S_RD_META : S_BYTE;
                end
            end
            S_BYTE:
            begin
                if (sts.line_end)
                begin
                    cmd.split_init = 1'b1;
                    state_next     = S_SPLIT_RD;
                end
                else
                begin
                    cmd.byte_exec = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SPLIT_RD:
            begin
                if (sts.at_end)
                begin
                    state_next = S_SPLIT_FIN;
                end
                else
                begin
                    cmd.line_rd = 1'b1;
                    state_next  = S_SPLIT_PROC;
                end
            end
            S_SPLIT_PROC:
            begin
                cmd.split_step = 1'b1;
                state_next     = S_SPLIT_RD;
            end
            S_SPLIT_FIN:
            begin
                cmd.split_fin = 1'b1;
                state_next    = S_IDLE;
            end
            S_RD_META:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = S_RD_DEC;
            end
            S_RD_DEC:
            begin
                if (sts.rd_ok)
                begin
                    cmd.chr_start = 1'b1;
                    state_next    = S_CHR_RD;
                end
                else
                begin
                    cmd.rd_single = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CHR_RD:
            begin
                cmd.chr_rd = 1'b1;
                state_next = S_CHR_OUT;
            end
            S_CHR_OUT:
            begin
                cmd.chr_emit = 1'b1;
                state_next   = sts.chr_last ? S_IDLE : S_CHR_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/nsfs_dp.sv */
// Datapath of the field splitter: line buffer, field stores, header capture,
// split counters, read decision and the result register.
// Depends on nsfs_pkg and nsfs_ram.
module nsfs_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  nsfs_pkg::item_t   item,
    input  logic              cfg_valid,
    input  logic [4:0]        cfg_data,
    input  nsfs_pkg::cmd_t    cmd,
    output nsfs_pkg::sts_t    sts,
    output logic              res_strobe,
    output nsfs_pkg::result_t res
);

    import nsfs_pkg::*;

    item_t              item_reg;
    logic [4:0]         mask_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               in_sent_reg;
    logic               cr_reg;
    logic [23:0]        hdr_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic [2:0]         kind_reg;
    logic [POS_W-1:0]   idx_reg;
    logic               started_reg;
    logic [CUR_W-1:0]   cur_reg;
    logic [FCNT_W-1:0]  flen_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [FIDX_W-1:0]  clen_reg;
    logic [FIDX_W-1:0]  cidx_reg;
    logic               strobe_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               strobe_next;

    logic [7:0]         line_q;
    logic [META_W-1:0]  meta_q;
    logic [7:0]         char_q;
    logic               line_we;
    logic [LINE_AW-1:0] line_waddr;
    logic               meta_we;
    logic [SLOT_W-1:0]  meta_addr;
    logic [META_W-1:0]  meta_wdata;
    logic               char_we;
    logic [CHAR_AW-1:0] char_waddr;
    logic [CHAR_AW-1:0] char_raddr;
    logic [2:0]         class_kind;
    logic [SLOT_W-1:0]  split_slot;
    logic               commit_ok;
    logic               rd_bad;
    logic [2:0]         rd_code;
    logic               is_comma;

    function automatic logic in_sent_reg_store();
        in_sent_reg_store = (item_reg.rx_byte == CH_DOLLAR) ||
                            (in_sent_reg && (int'(pos_reg) < LINE_BYTES));
    endfunction

    // Classify by header characters 3 to 5
    always_comb
    begin
        class_kind = KIND_UNKNOWN;
        if (pos_reg >= POS_W'(6))
        begin
            if (hdr_reg == HDR_RMC)
                class_kind = KIND_RMC;
            else if (mask_reg[0] && hdr_reg == HDR_VTG)
                class_kind = KIND_VTG;
            else if (mask_reg[1] && hdr_reg == HDR_GGA)
                class_kind = KIND_GGA;
            else if (mask_reg[2] && hdr_reg == HDR_GSA)
                class_kind = KIND_GSA;
            else if (mask_reg[3] && hdr_reg == HDR_GSV)
                class_kind = KIND_GSV;
            else if (mask_reg[4] && hdr_reg == HDR_GLL)
                class_kind = KIND_GLL;
        end
        if (int'(class_kind) >= KINDS)
            class_kind = KIND_UNKNOWN;
    end

    // Split pass addressing and commit condition
    assign split_slot = SLOT_W'(int'(kind_reg) * MAX_FIELDS + int'(cur_reg));
    assign commit_ok  = started_reg && (int'(cur_reg) < MAX_FIELDS);
    assign is_comma   = (line_q == CH_COMMA);

    assign line_we    = cmd.byte_exec && in_sent_reg_store();
    assign line_waddr = (item_reg.rx_byte == CH_DOLLAR) ? '0 : pos_reg[LINE_AW-1:0];

    assign meta_we    = (cmd.split_step && is_comma && commit_ok) ||
                        (cmd.split_fin && commit_ok);
    assign meta_wdata = (int'(flen_reg) >= FIELD_BYTES) ? {1'b1, {FIDX_W{1'b0}}}
                                                        : {1'b0, flen_reg[FIDX_W-1:0]};
    assign meta_addr  = meta_we ? split_slot : rd_slot_reg;

    assign char_we    = cmd.split_step && !is_comma && commit_ok &&
                        (int'(flen_reg) < FIELD_BYTES - 1);
    assign char_waddr = CHAR_AW'(int'(split_slot) * FIELD_BYTES + int'(flen_reg));
    assign char_raddr = CHAR_AW'(int'(rd_slot_reg) * FIELD_BYTES + int'(cidx_reg));

    // Read request checks and decision
    assign rd_bad = (int'(item_reg.sentence_kind) >= KINDS) ||
                    (item_reg.field_number == 5'd0) ||
                    (int'(item_reg.field_number) > MAX_FIELDS);

    always_comb
    begin
        if (rd_bad || !valid_reg[rd_slot_reg])
            rd_code = ST_NODATA;
        else if (meta_q[META_W-1])
            rd_code = ST_OVF;
        else if (meta_q[FIDX_W-1:0] == '0)
            rd_code = ST_NODATA;
        else if ((9'(meta_q[FIDX_W-1:0]) + 9'd1) > 9'(item_reg.dest_capacity))
            rd_code = ST_OVF;
        else
            rd_code = ST_OK;
    end

    assign sts.line_end = in_sent_reg && cr_reg && (item_reg.rx_byte == CH_LF) &&
                          (item_reg.rx_byte != CH_DOLLAR);
    assign sts.at_end   = (idx_reg == pos_reg - POS_W'(1));
    assign sts.rd_ok    = (rd_code == ST_OK);
    assign sts.chr_last = (cidx_reg == clen_reg - FIDX_W'(1));

    // Memories
    nsfs_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (item_reg.rx_byte),
        .raddr (idx_reg[LINE_AW-1:0]),
        .rdata (line_q)
    );

    nsfs_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_addr),
        .wdata (meta_wdata),
        .raddr (meta_addr),
        .rdata (meta_q)
    );

    nsfs_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_chars (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (line_q),
        .raddr (char_raddr),
        .rdata (char_q)
    );

    // Result selection
    always_comb
    begin
        res_next    = '0;
        strobe_next = 1'b0;
        res_next.last = 1'b1;
        if (cmd.byte_exec)
        begin
            strobe_next     = 1'b1;
            res_next.status = (item_reg.rx_byte != CH_DOLLAR && in_sent_reg &&
                               int'(pos_reg) >= LINE_BYTES) ? ST_DISCARD : ST_BYTE;
        end
        else if (cmd.split_fin)
        begin
            strobe_next       = 1'b1;
            res_next.status   = ST_STORED;
            res_next.kind_out = kind_reg;
        end
        else if (cmd.rd_single)
        begin
            strobe_next       = 1'b1;
            res_next.status   = rd_code;
            res_next.kind_out = item_reg.sentence_kind;
        end
        else if (cmd.chr_emit)
        begin
            strobe_next        = 1'b1;
            res_next.status    = ST_OK;
            res_next.kind_out  = item_reg.sentence_kind;
            res_next.field_len = 4'(clen_reg);
            res_next.data_byte = char_q;
            res_next.last      = sts.chr_last;
        end
    end

    // Hold the item, read slot, character counters, split kind and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            rd_slot_reg <= SLOT_W'(int'(item.sentence_kind) * MAX_FIELDS +
                                   int'(item.field_number) - 1);
        end
        if (cmd.chr_start)
        begin
            clen_reg <= meta_q[FIDX_W-1:0];
            cidx_reg <= '0;
        end
        if (cmd.chr_emit)
        begin
            cidx_reg <= cidx_reg + FIDX_W'(1);
        end
        if (cmd.split_init)
        begin
            kind_reg <= class_kind;
        end
        res_reg <= res_next;
    end

    // Line state, split counters, field valid bits, mask and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= 5'd31;
            pos_reg     <= '0;
            in_sent_reg <= 1'b0;
            cr_reg      <= 1'b0;
            hdr_reg     <= '0;
            valid_reg   <= '0;
            idx_reg     <= '0;
            started_reg <= 1'b0;
            cur_reg     <= '0;
            flen_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            if (cfg_valid)
            begin
                mask_reg <= cfg_data;
            end
            // Take one byte
            if (cmd.byte_exec)
            begin
                if (item_reg.rx_byte == CH_DOLLAR)
                begin
                    pos_reg     <= POS_W'(1);
                    in_sent_reg <= 1'b1;
                    cr_reg      <= 1'b0;
                end
                else if (in_sent_reg)
                begin
                    if (int'(pos_reg) >= LINE_BYTES)
                    begin
                        pos_reg     <= '0;
                        in_sent_reg <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                        cr_reg  <= (item_reg.rx_byte == CH_CR);
                        if (pos_reg == POS_W'(3))
                            hdr_reg[23:16] <= item_reg.rx_byte;
                        if (pos_reg == POS_W'(4))
                            hdr_reg[15:8] <= item_reg.rx_byte;
                        if (pos_reg == POS_W'(5))
                            hdr_reg[7:0] <= item_reg.rx_byte;
                    end
                end
            end
            // Start the split: drop all fields of the target kind
            if (cmd.split_init)
            begin
                for (int k = 0; k < KINDS; k++)
                begin
                    for (int f = 0; f < MAX_FIELDS; f++)
                    begin
                        if (class_kind == 3'(k))
                            valid_reg[k * MAX_FIELDS + f] <= 1'b0;
                    end
                end
                idx_reg     <= '0;
                started_reg <= 1'b0;
                cur_reg     <= '0;
                flen_reg    <= '0;
            end
            // Advance over one line character
            if (cmd.split_step)
            begin
                idx_reg <= idx_reg + POS_W'(1);
                if (is_comma)
                begin
                    if (commit_ok)
                        valid_reg[split_slot] <= 1'b1;
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        cur_reg     <= '0;
                    end
                    else if (int'(cur_reg) < MAX_FIELDS)
                    begin
                        cur_reg <= cur_reg + CUR_W'(1);
                    end
                    flen_reg <= '0;
                end
                else if (started_reg && int'(flen_reg) < FIELD_BYTES)
                begin
                    flen_reg <= flen_reg + FCNT_W'(1);
                end
            end
            // Close the last field and end the sentence
            if (cmd.split_fin)
            begin
                if (commit_ok)
                    valid_reg[split_slot] <= 1'b1;
                pos_reg     <= '0;
                in_sent_reg <= 1'b0;
                cr_reg      <= 1'b0;
            end
        end
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

endmodule

/* rtl/core/nmea_sentence_field_splitter_top.sv */
// Top level of the NMEA sentence field splitter: controller plus datapath.
// Depends on nsfs_pkg, nsfs_ctrl, nsfs_dp (and nsfs_ram below it).
//
//   channel   signals                          handshake
//   item      start, busy, item                taken when start && !busy
//   result    res_strobe, res                  a single strobe per result, no stall
//   config    cfg_valid, cfg_ready, cfg_data   taken when valid && ready
//
// A byte that ends a sentence starts a split pass over the single-port line
// buffer: each buffered character before the CR is read and then processed,
// and the last field is closed at the end. A read fetches the field's length
// first, then issues one result or reads and emits its characters in turn.
// The field store needs no clearing pass: valid bits reset with rst_n.
// Results cannot be held off; busy stays high until the last one is issued.
module nmea_sentence_field_splitter_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nsfs_pkg::item_t   item,
    output logic              res_strobe,
    output nsfs_pkg::result_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data
);

    import nsfs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    nsfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (item.req_type),
        .busy     (busy),
        .cmd      (cmd),
        .sts      (sts)
    );

    nsfs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .res_strobe (res_strobe),
        .res        (res)
    );

endmodule

/* rtl/core/nsfs_chk.sv */
// Port-level checker for the field splitter, bound to the top level.
// Depends on nsfs_pkg and nmea_sentence_field_splitter_top.
module nsfs_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              res_strobe,
    input nsfs_pkg::result_t res
);

    import nsfs_pkg::*;

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after accepted item");

    // A result seen while idle comes right after busy work
    a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !busy |-> $past(busy))
        else $error("result without work in progress");

    // Field characters carry a nonzero length
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.status == ST_OK |-> res.field_len != 4'd0)
        else $error("ok result with zero length");

    // Non-character results are single, empty and marked last
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.status != ST_OK |-> res.last && res.data_byte == 8'd0 &&
        res.field_len == 4'd0)
        else $error("malformed single result");

endmodule

bind nmea_sentence_field_splitter_top nsfs_chk u_nsfs_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .res_strobe (res_strobe),
    .res        (res)
);
